/* hdl/lsgd_pkg.sv */
`timescale 1ns / 1ps

package lsgd_pkg;

    localparam int LSGD_MAX_DIM = 3;
    localparam int COMP_MAX     = 3;
    localparam int DATA_W       = 32;
    localparam int SUM_W        = 64;
    localparam int NP_W         = 2 * DATA_W + 1;
    localparam int PROD_W       = 2 * (DATA_W + 1);
    localparam int ACC_W        = DATA_W + SUM_W + 2;
    localparam int TRACE_W      = DATA_W + 2;
    localparam int CFG_IDX_W    = 1;
    localparam int CFG_DATA_W   = 2;

    localparam logic [1:0] OP_LOAD_INV   = 2'd0;
    localparam logic [1:0] OP_SET_CENTER = 2'd1;
    localparam logic [1:0] OP_NEIGHBOR   = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_DIM  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_COMP = 1'b1;

    localparam logic [1:0] DIM_MIN   = 2'd2;
    localparam logic [1:0] COMP_MIN  = 2'd1;
    localparam logic [1:0] RST_DIM   = 2'd3;
    localparam logic [1:0] RST_COMP  = 2'd3;

    typedef struct packed {
        logic       ld_inv;
        logic       set_ctr;
        logic       nb_latch;
        logic       nb_issue;
        logic       emit_rd;
        logic       trace_clr;
        logic       mul_issue;
        logic       mul_clr;
        logic       mul_fin;
        logic       emit_out;
        logic       last_row;
        logic [1:0] row;
        logic [1:0] ax_i;
        logic [1:0] ax_j;
        logic       half;
        logic [1:0] dim;
        logic [1:0] nc;
    } t_cmd;

endpackage

/* hdl/ls_gradient_divergence.sv */
`timescale 1ns / 1ps

// Least-squares gradient and divergence unit, Q16.16 throughout.
// Command channel: an item transfers on a rising edge with start high and
// busy low. Opcode 0 loads an inverse row, opcode 1 sets the center and
// clears the moment sums; for both, busy stays low.
// Opcode 2 adds a neighbor: busy is high while its NC active components are
// added, so the next neighbor transfers only after busy falls; the offset
// multipliers, one per axis, cover one component per cycle, and the sum
// store, with one read and one write port, limits it to one row read and
// one row write. A neighbor with last set then emits one gradient row per
// component: each row reads its sums, runs its D*D products (D active axes)
// on the one shared 32x33 multiplier, which forms every 32x64 product in
// two halves, then drains the product pipeline and is registered out.
// Rows appear on the o_ ports for one cycle with o_strobe high; the
// receiver cannot stall them. Divergence is carried on the final row, and
// busy falls as that row appears.
// Configuration writes are taken on any edge with i_cfg_we high.
// Synchronous reset clears the inverse, center and sums; goes idle at once.

module ls_gradient_divergence #(
    parameter int MAX_DIM = lsgd_pkg::LSGD_MAX_DIM
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                start,
    output logic                                busy,
    input  logic [1:0]                          i_opcode,
    input  logic [1:0]                          i_row,
    input  logic signed [lsgd_pkg::DATA_W-1:0]  i_off_x,
    input  logic signed [lsgd_pkg::DATA_W-1:0]  i_off_y,
    input  logic signed [lsgd_pkg::DATA_W-1:0]  i_off_z,
    input  logic signed [lsgd_pkg::DATA_W-1:0]  i_val_0,
    input  logic signed [lsgd_pkg::DATA_W-1:0]  i_val_1,
    input  logic signed [lsgd_pkg::DATA_W-1:0]  i_val_2,
    input  logic                                i_last,
    input  logic                                i_cfg_we,
    input  logic [lsgd_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [lsgd_pkg::CFG_DATA_W-1:0]     i_cfg_data,
    output logic                                o_strobe,
    output logic [1:0]                          o_out_row,
    output logic signed [lsgd_pkg::DATA_W-1:0]  o_grad_x,
    output logic signed [lsgd_pkg::DATA_W-1:0]  o_grad_y,
    output logic signed [lsgd_pkg::DATA_W-1:0]  o_grad_z,
    output logic signed [lsgd_pkg::DATA_W-1:0]  o_divergence,
    output logic                                o_last_row
);
    import lsgd_pkg::*;

    t_cmd s_cmd;

    lsgd_ctrl #(
        .MAX_DIM (MAX_DIM)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .start       (start),
        .busy        (busy),
        .i_opcode    (i_opcode),
        .i_last      (i_last),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cmd       (s_cmd)
    );

    lsgd_dp #(
        .MAX_DIM (MAX_DIM)
    ) u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (s_cmd),
        .i_row        (i_row),
        .i_off_x      (i_off_x),
        .i_off_y      (i_off_y),
        .i_off_z      (i_off_z),
        .i_val_0      (i_val_0),
        .i_val_1      (i_val_1),
        .i_val_2      (i_val_2),
        .o_strobe     (o_strobe),
        .o_out_row    (o_out_row),
        .o_grad_x     (o_grad_x),
        .o_grad_y     (o_grad_y),
        .o_grad_z     (o_grad_z),
        .o_divergence (o_divergence),
        .o_last_row   (o_last_row)
    );

endmodule

/* hdl/lsgd_ctrl.sv */
`timescale 1ns / 1ps

module lsgd_ctrl #(
    parameter int MAX_DIM = lsgd_pkg::LSGD_MAX_DIM
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             start,
    output logic                             busy,
    input  logic [1:0]                       i_opcode,
    input  logic                             i_last,
    input  logic                             i_cfg_we,
    input  logic [lsgd_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [lsgd_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    output lsgd_pkg::t_cmd                   o_cmd
);
    import lsgd_pkg::*;

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_NB     = 3'd1;
    localparam logic [2:0] S_NB_END = 3'd2;
    localparam logic [2:0] S_E_RD   = 3'd3;
    localparam logic [2:0] S_E_MUL  = 3'd4;
    localparam logic [2:0] S_E_FL1  = 3'd5;
    localparam logic [2:0] S_E_FL2  = 3'd6;
    localparam logic [2:0] S_E_OUT  = 3'd7;

    localparam logic [1:0] DIM_CAP = 2'(MAX_DIM);

    logic [2:0] r_state, n_state;
    logic [1:0] r_d, n_d;
    logic [1:0] r_i, n_i;
    logic [1:0] r_j, n_j;
    logic       r_h, n_h;
    logic       r_last, n_last;
    logic [1:0] r_dim, r_comp;
    logic [1:0] s_dim, s_nc, s_dim_last, s_nc_last;
    logic       s_accept;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dim  <= RST_DIM;
            r_comp <= RST_COMP;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_DIM:  r_dim  <= i_cfg_data;
                CFG_COMP: r_comp <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        if (r_dim < DIM_MIN) begin
            s_dim = DIM_MIN;
        end else if (r_dim > DIM_CAP) begin
            s_dim = DIM_CAP;
        end else begin
            s_dim = r_dim;
        end
        s_nc       = (r_comp < COMP_MIN) ? COMP_MIN : r_comp;
        s_dim_last = s_dim - 2'd1;
        s_nc_last  = s_nc - 2'd1;
    end

    assign busy     = (r_state != S_IDLE);
    assign s_accept = start && !busy;

    always_comb begin
        n_state = r_state;
        n_d     = r_d;
        n_i     = r_i;
        n_j     = r_j;
        n_h     = r_h;
        n_last  = r_last;
        o_cmd   = '0;
        o_cmd.row  = r_d;
        o_cmd.ax_i = r_i;
        o_cmd.ax_j = r_j;
        o_cmd.half = r_h;
        o_cmd.dim  = s_dim;
        o_cmd.nc   = s_nc;
        case (r_state)
            S_IDLE: begin
                if (s_accept) begin
                    case (i_opcode)
                        OP_LOAD_INV:   o_cmd.ld_inv  = 1'b1;
                        OP_SET_CENTER: o_cmd.set_ctr = 1'b1;
                        OP_NEIGHBOR: begin
                            o_cmd.nb_latch = 1'b1;
                            n_d     = '0;
                            n_last  = i_last;
                            n_state = S_NB;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            S_NB: begin
                o_cmd.nb_issue = 1'b1;
                if (r_d >= s_nc_last) begin
                    n_state = S_NB_END;
                end else begin
                    n_d = r_d + 2'd1;
                end
            end
            S_NB_END: begin
                n_d     = '0;
                n_state = r_last ? S_E_RD : S_IDLE;
            end
            S_E_RD: begin
                o_cmd.emit_rd   = 1'b1;
                o_cmd.trace_clr = (r_d == 2'd0);
                n_i     = '0;
                n_j     = '0;
                n_h     = 1'b0;
                n_state = S_E_MUL;
            end
            S_E_MUL: begin
                o_cmd.mul_issue = 1'b1;
                o_cmd.mul_clr   = (r_j == 2'd0) && !r_h;
                o_cmd.mul_fin   = (r_j >= s_dim_last) && r_h;
                n_h = !r_h;
                if (r_h) begin
                    if (r_j >= s_dim_last) begin
                        n_j = '0;
                        if (r_i >= s_dim_last) begin
                            n_state = S_E_FL1;
                        end else begin
                            n_i = r_i + 2'd1;
                        end
                    end else begin
                        n_j = r_j + 2'd1;
                    end
                end
            end
            S_E_FL1: n_state = S_E_FL2;
            S_E_FL2: n_state = S_E_OUT;
            S_E_OUT: begin
                o_cmd.emit_out = 1'b1;
                o_cmd.last_row = (r_d >= s_nc_last);
                if (r_d >= s_nc_last) begin
                    n_state = S_IDLE;
                end else begin
                    n_d     = r_d + 2'd1;
                    n_state = S_E_RD;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_d     <= '0;
            r_i     <= '0;
            r_j     <= '0;
            r_h     <= 1'b0;
            r_last  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_d     <= n_d;
            r_i     <= n_i;
            r_j     <= n_j;
            r_h     <= n_h;
            r_last  <= n_last;
        end
    end

    a_nb_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_accept && i_opcode == OP_NEIGHBOR) |=> busy)
        else $error("neighbor transfer did not raise busy");

    a_out_next: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_E_OUT) |=> (r_state == S_IDLE || r_state == S_E_RD))
        else $error("row output not followed by next row or idle");

    a_idle_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE) |-> !(o_cmd.nb_issue || o_cmd.mul_issue || o_cmd.emit_out))
        else $error("datapath command issued while idle");

endmodule

/* hdl/lsgd_dp.sv */
`timescale 1ns / 1ps

module lsgd_dp #(
    parameter int MAX_DIM = lsgd_pkg::LSGD_MAX_DIM
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  lsgd_pkg::t_cmd                      i_cmd,
    input  logic [1:0]                          i_row,
    input  logic signed [lsgd_pkg::DATA_W-1:0]  i_off_x,
    input  logic signed [lsgd_pkg::DATA_W-1:0]  i_off_y,
    input  logic signed [lsgd_pkg::DATA_W-1:0]  i_off_z,
    input  logic signed [lsgd_pkg::DATA_W-1:0]  i_val_0,
    input  logic signed [lsgd_pkg::DATA_W-1:0]  i_val_1,
    input  logic signed [lsgd_pkg::DATA_W-1:0]  i_val_2,
    output logic                                o_strobe,
    output logic [1:0]                          o_out_row,
    output logic signed [lsgd_pkg::DATA_W-1:0]  o_grad_x,
    output logic signed [lsgd_pkg::DATA_W-1:0]  o_grad_y,
    output logic signed [lsgd_pkg::DATA_W-1:0]  o_grad_z,
    output logic signed [lsgd_pkg::DATA_W-1:0]  o_divergence,
    output logic                                o_last_row
);
    import lsgd_pkg::*;

    localparam int AX_W  = $clog2(MAX_DIM);
    localparam int ROW_W = MAX_DIM * SUM_W;
    localparam logic signed [DATA_W-1:0] Q_MAX = {1'b0, {(DATA_W-1){1'b1}}};
    localparam logic signed [DATA_W-1:0] Q_MIN = {1'b1, {(DATA_W-1){1'b0}}};
    localparam logic [SUM_W-1:0] S_MAX = {1'b0, {(SUM_W-1){1'b1}}};
    localparam logic [SUM_W-1:0] S_MIN = {1'b1, {(SUM_W-1){1'b0}}};

    logic signed [DATA_W-1:0] s_off_in [COMP_MAX];
    logic signed [DATA_W-1:0] s_val_in [COMP_MAX];

    logic signed [DATA_W-1:0] r_inv [MAX_DIM][MAX_DIM];
    logic signed [DATA_W-1:0] r_ctr [COMP_MAX];
    logic signed [DATA_W-1:0] r_off [MAX_DIM];
    logic signed [DATA_W-1:0] r_val [COMP_MAX];

    logic [ROW_W-1:0]    r_sum_mem [COMP_MAX];
    logic [COMP_MAX-1:0] r_sum_vld;
    logic [ROW_W-1:0]    r_rd_data;
    logic                r_rd_vld;
    logic [ROW_W-1:0]    s_rd_row;
    logic                s_rd_en;

    logic signed [DATA_W:0]   s_diff;
    logic signed [NP_W-1:0]   r_np [MAX_DIM];
    logic                     r_wr_pend;
    logic [1:0]               r_wr_row;
    logic [ROW_W-1:0]         s_wr_data;

    logic [SUM_W-1:0]         s_cols [MAX_DIM];
    logic [SUM_W-1:0]         s_col;
    logic signed [DATA_W:0]   s_mb;
    logic signed [PROD_W-1:0] r_prod;
    logic                     r_ep_vld, r_ep_h, r_ep_clr, r_ep_fin;
    logic [1:0]               r_ep_i;
    logic signed [ACC_W-1:0]  r_acc;
    logic signed [ACC_W-1:0]  s_addend;
    logic                     r_acc_fin;
    logic [1:0]               r_acc_i;
    logic signed [DATA_W-1:0] s_g;
    logic signed [DATA_W-1:0] r_g [MAX_DIM];
    logic signed [DATA_W-1:0] s_gz;

    logic signed [TRACE_W-1:0] r_trace, s_tr_add, s_tr_next;
    logic signed [DATA_W-1:0]  s_div;

    logic                     r_strobe, r_last_row;
    logic [1:0]               r_out_row;
    logic signed [DATA_W-1:0] r_gx, r_gy, r_gz, r_div;

    assign s_off_in[0] = i_off_x;
    assign s_off_in[1] = i_off_y;
    assign s_off_in[2] = i_off_z;
    assign s_val_in[0] = i_val_0;
    assign s_val_in[1] = i_val_1;
    assign s_val_in[2] = i_val_2;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int r = 0; r < MAX_DIM; r++) begin
                for (int c = 0; c < MAX_DIM; c++) begin
                    r_inv[r][c] <= '0;
                end
            end
            for (int c = 0; c < COMP_MAX; c++) begin
                r_ctr[c] <= '0;
            end
        end else begin
            if (i_cmd.ld_inv && (i_row < 2'(MAX_DIM))) begin
                for (int c = 0; c < MAX_DIM; c++) begin
                    r_inv[i_row[AX_W-1:0]][c] <= s_val_in[c];
                end
            end
            if (i_cmd.set_ctr) begin
                for (int c = 0; c < COMP_MAX; c++) begin
                    r_ctr[c] <= s_val_in[c];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.nb_latch) begin
            for (int k = 0; k < MAX_DIM; k++) begin
                r_off[k] <= s_off_in[k];
            end
            for (int c = 0; c < COMP_MAX; c++) begin
                r_val[c] <= s_val_in[c];
            end
        end
    end

    assign s_rd_en  = i_cmd.nb_issue || i_cmd.emit_rd;
    assign s_rd_row = r_rd_vld ? r_rd_data : '0;

    always_ff @(posedge i_clk) begin
        if (r_wr_pend) begin
            r_sum_mem[r_wr_row] <= s_wr_data;
        end
        if (s_rd_en) begin
            r_rd_data <= r_sum_mem[i_cmd.row];
            r_rd_vld  <= r_sum_vld[i_cmd.row];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sum_vld <= '0;
        end else if (i_cmd.set_ctr) begin
            r_sum_vld <= '0;
        end else if (r_wr_pend) begin
            r_sum_vld[r_wr_row] <= 1'b1;
        end
    end

    assign s_diff = {r_val[i_cmd.row][DATA_W-1], r_val[i_cmd.row]}
                  - {r_ctr[i_cmd.row][DATA_W-1], r_ctr[i_cmd.row]};

    always_ff @(posedge i_clk) begin
        if (i_cmd.nb_issue) begin
            for (int k = 0; k < MAX_DIM; k++) begin
                r_np[k] <= s_diff * r_off[k];
            end
            r_wr_row <= i_cmd.row;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_pend <= 1'b0;
        end else begin
            r_wr_pend <= i_cmd.nb_issue;
        end
    end

    always_comb begin
        logic [SUM_W-1:0] v_old;
        logic [SUM_W-1:0] v_inc;
        logic [SUM_W:0]   v_sum;
        s_wr_data = '0;
        for (int k = 0; k < MAX_DIM; k++) begin
            v_old = s_rd_row[k*SUM_W +: SUM_W];
            v_inc = {{(SUM_W-NP_W+16){r_np[k][NP_W-1]}}, r_np[k][NP_W-1:16]};
            v_sum = {v_old[SUM_W-1], v_old} + {v_inc[SUM_W-1], v_inc};
            if (2'(k) >= i_cmd.dim) begin
                s_wr_data[k*SUM_W +: SUM_W] = v_old;
            end else if (v_sum[SUM_W] != v_sum[SUM_W-1]) begin
                s_wr_data[k*SUM_W +: SUM_W] = v_sum[SUM_W] ? S_MIN : S_MAX;
            end else begin
                s_wr_data[k*SUM_W +: SUM_W] = v_sum[SUM_W-1:0];
            end
        end
    end

    always_comb begin
        for (int k = 0; k < MAX_DIM; k++) begin
            s_cols[k] = s_rd_row[k*SUM_W +: SUM_W];
        end
        s_col = s_cols[i_cmd.ax_j[AX_W-1:0]];
        if (i_cmd.half) begin
            s_mb = {s_col[SUM_W-1], s_col[SUM_W-1:DATA_W]};
        end else begin
            s_mb = {1'b0, s_col[DATA_W-1:0]};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.mul_issue) begin
            r_prod   <= r_inv[i_cmd.ax_i[AX_W-1:0]][i_cmd.ax_j[AX_W-1:0]] * s_mb;
            r_ep_h   <= i_cmd.half;
            r_ep_clr <= i_cmd.mul_clr;
            r_ep_fin <= i_cmd.mul_fin;
            r_ep_i   <= i_cmd.ax_i;
        end
    end

    always_comb begin
        if (r_ep_h) begin
            s_addend = {r_prod, {DATA_W{1'b0}}};
        end else begin
            s_addend = {{(ACC_W-PROD_W){r_prod[PROD_W-1]}}, r_prod};
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_ep_vld) begin
            r_acc   <= (r_ep_clr ? '0 : r_acc) + s_addend;
            r_acc_i <= r_ep_i;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ep_vld  <= 1'b0;
            r_acc_fin <= 1'b0;
        end else begin
            r_ep_vld  <= i_cmd.mul_issue;
            r_acc_fin <= r_ep_vld && r_ep_fin;
        end
    end

    always_comb begin
        if ((&r_acc[ACC_W-1:DATA_W+15]) || !(|r_acc[ACC_W-1:DATA_W+15])) begin
            s_g = r_acc[DATA_W+15:16];
        end else begin
            s_g = r_acc[ACC_W-1] ? Q_MIN : Q_MAX;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit_rd) begin
            for (int k = 0; k < MAX_DIM; k++) begin
                r_g[k] <= '0;
            end
        end else if (r_acc_fin) begin
            r_g[r_acc_i[AX_W-1:0]] <= s_g;
        end
    end

    if (MAX_DIM > 2) begin : g_axis_z
        assign s_gz = r_g[2];
    end else begin : g_no_axis_z
        assign s_gz = '0;
    end

    always_comb begin
        if ((i_cmd.nc > COMP_MIN) && (i_cmd.row < i_cmd.dim)) begin
            s_tr_add = TRACE_W'(r_g[i_cmd.row[AX_W-1:0]]);
        end else begin
            s_tr_add = '0;
        end
        s_tr_next = r_trace + s_tr_add;
        if ((&s_tr_next[TRACE_W-1:DATA_W-1]) || !(|s_tr_next[TRACE_W-1:DATA_W-1])) begin
            s_div = s_tr_next[DATA_W-1:0];
        end else begin
            s_div = s_tr_next[TRACE_W-1] ? Q_MIN : Q_MAX;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit_rd && i_cmd.trace_clr) begin
            r_trace <= '0;
        end else if (i_cmd.emit_out) begin
            r_trace <= s_tr_next;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit_out) begin
            r_out_row  <= i_cmd.row;
            r_gx       <= r_g[0];
            r_gy       <= r_g[1];
            r_gz       <= s_gz;
            r_div      <= i_cmd.last_row ? s_div : '0;
            r_last_row <= i_cmd.last_row;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_strobe <= 1'b0;
        end else begin
            r_strobe <= i_cmd.emit_out;
        end
    end

    assign o_strobe     = r_strobe;
    assign o_out_row    = r_out_row;
    assign o_grad_x     = r_gx;
    assign o_grad_y     = r_gy;
    assign o_grad_z     = r_gz;
    assign o_divergence = r_div;
    assign o_last_row   = r_last_row;

    a_drained: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.emit_out |-> (!r_wr_pend && !r_ep_vld && !r_acc_fin))
        else $error("row shown before the product pipeline drained");

    a_clear_safe: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.set_ctr |-> !r_wr_pend)
        else $error("sum clear overlaps a pending sum write");

    a_strobe_pulse: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_strobe |=> !r_strobe)
        else $error("result strobe held longer than one cycle");

endmodule

/* tb/sv/lsgd_check_pkg.sv */
`timescale 1ns / 1ps

package lsgd_check_pkg;

    import lsgd_pkg::*;

    localparam logic [1:0] OP_UNUSED  = 2'd3;
    localparam logic [1:0] ROW_UNUSED = 2'd3;

    typedef struct packed {
        logic [1:0]  opcode;
        logic [1:0]  row;
        logic [31:0] off_x;
        logic [31:0] off_y;
        logic [31:0] off_z;
        logic [31:0] val_0;
        logic [31:0] val_1;
        logic [31:0] val_2;
        logic        last;
    } t_grad_cmd;

    typedef struct packed {
        logic [1:0]  row;
        logic [31:0] gx;
        logic [31:0] gy;
        logic [31:0] gz;
        logic [31:0] divergence;
        logic        last_row;
    } t_grad_row;

    function automatic logic signed [31:0] clamp32(input logic signed [99:0] v);
        if (v[99:31] == {69{v[99]}})
            return v[31:0];
        return v[99] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
    endfunction

    function automatic logic signed [63:0] clamp64(input logic signed [65:0] v);
        if (v[65:63] == {3{v[65]}})
            return v[63:0];
        return v[65] ? 64'sh8000_0000_0000_0000 : 64'sh7FFF_FFFF_FFFF_FFFF;
    endfunction

    class grad_board;
        logic [1:0]         dim_reg;
        logic [1:0]         comp_reg;
        logic signed [31:0] inverse [3][3];
        logic signed [31:0] center [3];
        logic signed [63:0] sums [3][3];
        t_grad_row          rows_due [$];
        int                 failures;

        function new();
            dim_reg  = RST_DIM;
            comp_reg = RST_COMP;
            failures = 0;
            foreach (inverse[i, j]) inverse[i][j] = '0;
            foreach (sums[i, j]) sums[i][j] = '0;
            foreach (center[i]) center[i] = '0;
        endfunction

        function void note_failure(input string msg);
            failures++;
            if (failures <= 10)
                $display("%s", msg);
        endfunction

        function void write_reg(input logic [CFG_IDX_W-1:0] idx,
                                input logic [CFG_DATA_W-1:0] data);
            if (idx == CFG_DIM)
                dim_reg = data;
            else if (idx == CFG_COMP)
                comp_reg = data;
        endfunction

        function int pending();
            return rows_due.size();
        endfunction

        function void note_item(input t_grad_cmd c);
            int                 nd;
            int                 nc;
            logic signed [31:0] off [3];
            logic signed [31:0] val [3];
            logic signed [32:0] diff;
            logic signed [64:0] prod;
            logic signed [65:0] wide_sum;
            logic signed [99:0] acc;
            logic signed [31:0] g [3];
            logic signed [35:0] trace;
            t_grad_row          r;
            nd = int'((dim_reg < DIM_MIN) ? DIM_MIN : dim_reg);
            if (nd > LSGD_MAX_DIM)
                nd = LSGD_MAX_DIM;
            nc = int'((comp_reg < COMP_MIN) ? COMP_MIN : comp_reg);
            off[0] = c.off_x;
            off[1] = c.off_y;
            off[2] = c.off_z;
            val[0] = c.val_0;
            val[1] = c.val_1;
            val[2] = c.val_2;
            case (c.opcode)
                OP_LOAD_INV: begin
                    if (c.row != ROW_UNUSED)
                        for (int j = 0; j < 3; j++) inverse[c.row][j] = val[j];
                end
                OP_SET_CENTER: begin
                    for (int j = 0; j < 3; j++) center[j] = val[j];
                    foreach (sums[i, j]) sums[i][j] = '0;
                end
                OP_NEIGHBOR: begin
                    for (int d = 0; d < nc; d++) begin
                        diff = val[d] - center[d];
                        for (int j = 0; j < nd; j++) begin
                            prod = diff * off[j];
                            wide_sum = sums[d][j] + (prod >>> 16);
                            sums[d][j] = clamp64(wide_sum);
                        end
                    end
                    if (c.last) begin
                        trace = '0;
                        for (int d = 0; d < nc; d++) begin
                            for (int i = 0; i < 3; i++) g[i] = '0;
                            for (int i = 0; i < nd; i++) begin
                                acc = '0;
                                for (int j = 0; j < nd; j++)
                                    acc = acc + sums[d][j] * inverse[i][j];
                                g[i] = clamp32(acc >>> 16);
                            end
                            if (nc > 1 && d < nd)
                                trace = trace + g[d];
                            r.row        = 2'(d);
                            r.gx         = g[0];
                            r.gy         = g[1];
                            r.gz         = g[2];
                            r.divergence = '0;
                            r.last_row   = 1'b0;
                            if (d == nc - 1) begin
                                acc          = 100'(trace);
                                r.divergence = clamp32(acc);
                                r.last_row   = 1'b1;
                            end
                            rows_due.push_back(r);
                        end
                    end
                end
                default: ;
            endcase
        endfunction

        function void check_row(input t_grad_row got);
            t_grad_row want;
            if (rows_due.size() == 0) begin
                note_failure($sformatf("unexpected row %0d x %h y %h z %h div %h last %0b",
                    got.row, got.gx, got.gy, got.gz, got.divergence, got.last_row));
                return;
            end
            want = rows_due.pop_front();
            if (got.row !== want.row || got.gx !== want.gx || got.gy !== want.gy ||
                got.gz !== want.gz || got.divergence !== want.divergence ||
                got.last_row !== want.last_row)
                note_failure($sformatf(
                    {"row mismatch: exp row %0d x %h y %h z %h div %h last %0b, ",
                     "got row %0d x %h y %h z %h div %h last %0b"},
                    want.row, want.gx, want.gy, want.gz, want.divergence, want.last_row,
                    got.row, got.gx, got.gy, got.gz, got.divergence, got.last_row));
        endfunction

        function int final_failures();
            if (rows_due.size() != 0)
                note_failure($sformatf("%0d expected rows never arrived", rows_due.size()));
            return failures;
        endfunction
    endclass

endpackage

/* tb/sv/testbench.sv */
`timescale 1ns / 1ps

module testbench;

    import lsgd_pkg::*;
    import lsgd_check_pkg::*;

    localparam int WATCHDOG_LIMIT = 1000;
    localparam int SETTLE_CYCLES  = 8;
    localparam int RANDOM_ITEMS   = 280;
    localparam int PHASES         = 8;

    localparam logic [1:0] DIM_PLAN [6]  = '{2'd3, 2'd2, 2'd2, 2'd3, 2'd0, 2'd1};
    localparam logic [1:0] COMP_PLAN [6] = '{2'd3, 2'd1, 2'd3, 2'd1, 2'd2, 2'd0};

    logic                    i_clk       = 1'b0;
    logic                    i_rst_n     = 1'b0;
    logic                    start       = 1'b0;
    logic                    busy;
    logic [1:0]              i_opcode    = '0;
    logic [1:0]              i_row       = '0;
    logic signed [31:0]      i_off_x     = '0;
    logic signed [31:0]      i_off_y     = '0;
    logic signed [31:0]      i_off_z     = '0;
    logic signed [31:0]      i_val_0     = '0;
    logic signed [31:0]      i_val_1     = '0;
    logic signed [31:0]      i_val_2     = '0;
    logic                    i_last      = 1'b0;
    logic                    i_cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0]    i_cfg_index = '0;
    logic [CFG_DATA_W-1:0]   i_cfg_data  = '0;
    logic                    o_strobe;
    logic [1:0]              o_out_row;
    logic signed [31:0]      o_grad_x;
    logic signed [31:0]      o_grad_y;
    logic signed [31:0]      o_grad_z;
    logic signed [31:0]      o_divergence;
    logic                    o_last_row;

    grad_board board = new();
    t_grad_row seen;
    bit        gaps_on      = 1'b1;
    int        useful_items = 0;
    int        quiet        = 0;

    ls_gradient_divergence u_top (.*);

    initial begin
        forever #6 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_strobe === 1'b1) begin
            seen.row        = o_out_row;
            seen.gx         = o_grad_x;
            seen.gy         = o_grad_y;
            seen.gz         = o_grad_z;
            seen.divergence = o_divergence;
            seen.last_row   = o_last_row;
            board.check_row(seen);
        end
    end

    always @(posedge i_clk) begin
        if ((start && busy === 1'b0) || o_strobe === 1'b1)
            quiet <= 0;
        else
            quiet <= quiet + 1;
        if (quiet >= WATCHDOG_LIMIT) begin
            $display("** ls_gradient_divergence: FAILED **");
            $finish;
        end
    end

    function automatic logic [31:0] rand_q16();
        logic [31:0] r;
        r = $urandom;
        case ($urandom_range(0, 7))
            0:       return r;
            1:       return 32'h7FFF_FFFF;
            2:       return 32'h8000_0000;
            3:       return 32'h0000_0000;
            default: return {{12{r[19]}}, r[19:0]};
        endcase
    endfunction

    function automatic t_grad_cmd make_cmd(input logic [1:0] op, input logic [1:0] row,
                                           input logic [31:0] ox, input logic [31:0] oy,
                                           input logic [31:0] oz, input logic [31:0] v0,
                                           input logic [31:0] v1, input logic [31:0] v2,
                                           input logic last);
        t_grad_cmd c;
        c.opcode = op;
        c.row    = row;
        c.off_x  = ox;
        c.off_y  = oy;
        c.off_z  = oz;
        c.val_0  = v0;
        c.val_1  = v1;
        c.val_2  = v2;
        c.last   = last;
        return c;
    endfunction

    function automatic t_grad_cmd random_cmd(input logic [1:0] op, input logic [1:0] row,
                                             input logic last);
        return make_cmd(op, row, rand_q16(), rand_q16(), rand_q16(),
                        rand_q16(), rand_q16(), rand_q16(), last);
    endfunction

    task automatic put_item(input t_grad_cmd c);
        int gap;
        gap = 0;
        if (gaps_on && $urandom_range(0, 3) == 0)
            gap = $urandom_range(1, 9);
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_opcode <= c.opcode;
        i_row    <= c.row;
        i_off_x  <= c.off_x;
        i_off_y  <= c.off_y;
        i_off_z  <= c.off_z;
        i_val_0  <= c.val_0;
        i_val_1  <= c.val_1;
        i_val_2  <= c.val_2;
        i_last   <= c.last;
        start    <= 1'b1;
        do @(posedge i_clk); while (busy !== 1'b0);
        board.note_item(c);
        if (!(c.opcode == OP_UNUSED || (c.opcode == OP_LOAD_INV && c.row == ROW_UNUSED)))
            useful_items++;
    endtask

    // drop start, wait for every outstanding row, then let the block go idle
    task automatic settle();
        start <= 1'b0;
        while (board.pending() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        while (busy !== 1'b0) @(posedge i_clk);
    endtask

    task automatic configure(input logic [1:0] dim, input logic [1:0] comp);
        settle();
        i_cfg_we    <= 1'b1;
        i_cfg_index <= CFG_DIM;
        i_cfg_data  <= dim;
        @(posedge i_clk);
        board.write_reg(CFG_DIM, dim);
        i_cfg_index <= CFG_COMP;
        i_cfg_data  <= comp;
        @(posedge i_clk);
        board.write_reg(CFG_COMP, comp);
        i_cfg_we    <= 1'b0;
    endtask

    task automatic random_run();
        int r;
        int n;
        if ($urandom_range(0, 15) == 0)
            settle();
        if ($urandom_range(0, 2) == 0) begin
            r = $urandom_range(0, 2);
            for (int k = 0; k < 3; k++)
                put_item(random_cmd(OP_LOAD_INV, 2'((r + k) % 3),
                                    1'($urandom_range(0, 1))));
        end
        if ($urandom_range(0, 7) == 0) begin
            if ($urandom_range(0, 1))
                put_item(random_cmd(OP_UNUSED, 2'($urandom_range(0, 3)),
                                    1'($urandom_range(0, 1))));
            else
                put_item(random_cmd(OP_LOAD_INV, ROW_UNUSED, 1'($urandom_range(0, 1))));
        end
        if ($urandom_range(0, 7) != 0)
            put_item(random_cmd(OP_SET_CENTER, 2'($urandom_range(0, 3)),
                                1'($urandom_range(0, 1))));
        n = $urandom_range(1, 5);
        for (int k = 0; k < n; k++)
            put_item(random_cmd(OP_NEIGHBOR, 2'($urandom_range(0, 3)),
                                (k == n - 1) || ($urandom_range(0, 11) == 0)));
    endtask

    initial begin
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        put_item(make_cmd(OP_LOAD_INV, 2'd0, '0, '0, '0,
                          32'h0001_0000, 32'h7FFF_FFFF, 32'h8000_0000, 1'b1));
        put_item(make_cmd(OP_LOAD_INV, 2'd1, '0, '0, '0,
                          32'h0000_0000, 32'h0001_0000, 32'h0000_0000, 1'b0));
        put_item(make_cmd(OP_LOAD_INV, 2'd2, '0, '0, '0,
                          32'hFFFF_0000, 32'h0000_8000, 32'h0001_0000, 1'b0));
        put_item(make_cmd(OP_LOAD_INV, ROW_UNUSED, '0, '0, '0,
                          32'h1234_5678, 32'h8765_4321, 32'h7FFF_FFFF, 1'b1));
        put_item(make_cmd(OP_UNUSED, 2'd1, $urandom, $urandom, $urandom,
                          $urandom, $urandom, $urandom, 1'b1));
        put_item(make_cmd(OP_SET_CENTER, 2'd3, '0, '0, '0,
                          32'h8000_0000, 32'h7FFF_FFFF, 32'h0000_0000, 1'b1));
        put_item(make_cmd(OP_NEIGHBOR, 2'd2, 32'h7FFF_FFFF, 32'h8000_0000, 32'h0001_0000,
                          32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF, 1'b0));
        put_item(make_cmd(OP_NEIGHBOR, 2'd1, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000,
                          32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 1'b1));
        put_item(make_cmd(OP_NEIGHBOR, 2'd0, 32'h0000_8000, 32'hFFFF_8000, 32'h0000_0001,
                          32'h0000_0003, 32'hFFFF_FFFD, 32'h0001_0000, 1'b1));

        configure(2'd2, 2'd1);
        put_item(make_cmd(OP_SET_CENTER, 2'd0, '0, '0, '0,
                          32'h0000_4000, 32'hDEAD_BEEF, 32'h1234_5678, 1'b0));
        put_item(make_cmd(OP_NEIGHBOR, 2'd0, 32'h0001_0000, 32'hFFFF_0000, 32'h7FFF_FFFF,
                          32'h0002_0000, 32'h7FFF_FFFF, 32'h8000_0000, 1'b0));
        put_item(make_cmd(OP_NEIGHBOR, 2'd3, 32'hFFFE_0000, 32'h0000_C000, 32'h8000_0000,
                          32'hFFFF_0000, 32'h0000_0000, 32'h0000_0000, 1'b1));

        configure(2'd0, 2'd0);
        put_item(make_cmd(OP_NEIGHBOR, 2'd0, 32'h0000_1000, 32'h0000_2000, 32'h0000_0001,
                          32'h0000_5000, 32'h0000_0000, 32'h0000_0000, 1'b1));

        configure(2'd1, 2'd2);
        put_item(make_cmd(OP_LOAD_INV, 2'd1, '0, '0, '0,
                          32'h0000_8000, 32'h0001_8000, 32'h7FFF_FFFF, 1'b0));
        put_item(make_cmd(OP_SET_CENTER, 2'd2, '0, '0, '0,
                          32'h0001_0000, 32'hFFFF_0000, 32'h0000_8000, 1'b0));
        put_item(make_cmd(OP_NEIGHBOR, 2'd1, 32'h0003_0000, 32'hFFFD_0000, 32'h0001_0000,
                          32'h0004_0000, 32'h8000_0000, 32'h7FFF_FFFF, 1'b1));

        configure(2'd3, 2'd0);
        put_item(make_cmd(OP_NEIGHBOR, 2'd0, 32'hFFFF_F000, 32'h0000_0100, 32'h7FFF_FFFF,
                          32'h8000_0000, 32'h0000_0000, 32'h0000_0000, 1'b1));

        for (int phase = 0; phase < PHASES; phase++) begin
            if (phase < 6)
                configure(DIM_PLAN[phase], COMP_PLAN[phase]);
            else
                configure(2'($urandom_range(0, 3)), 2'($urandom_range(0, 3)));
            gaps_on = (phase < 6);
            while (useful_items < RANDOM_ITEMS * (phase + 1) / PHASES)
                random_run();
        end

        settle();
        if (board.final_failures() == 0)
            $display("** ls_gradient_divergence: PASSED **");
        else
            $display("** ls_gradient_divergence: FAILED **");
        $finish;
    end

endmodule
